// ===== src/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and encoding functions for the UTF-16 to UTF-8
// stream converter.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 2 * ByteW;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [UnitW-1:0] unit_t;
  typedef logic [1:0]       bidx_t;

  // Code unit push from the front end into the queue.
  typedef struct packed {
    logic  valid;
    unit_t unit;
  } push_t;

  // Queue status seen by both neighbours.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // One encoded byte together with its end-of-unit flag.
  typedef struct packed {
    logic  last;
    byte_t data;
  } obyte_t;

  // Number of UTF-8 bytes for a code unit: 1, 2 or 3.
  function automatic bidx_t utf8_len(unit_t unit);
    bidx_t len;
    if (unit[15:7] == 9'd0) begin
      len = 2'd1;
    end else if (unit[15:11] == 5'd0) begin
      len = 2'd2;
    end else begin
      len = 2'd3;
    end
    return len;
  endfunction

  // Byte number idx of the UTF-8 encoding of a code unit.
  function automatic obyte_t utf8_byte(unit_t unit, bidx_t idx);
    obyte_t ob;
    bidx_t  len;
    len = utf8_len(unit);
    ob  = '0;
    case (idx)
      2'd0: begin
        case (len)
          2'd1:    ob = '{last: 1'b1, data: unit[7:0]};
          2'd2:    ob = '{last: 1'b0, data: {3'b110, unit[10:6]}};
          default: ob = '{last: 1'b0, data: {4'b1110, unit[15:12]}};
        endcase
      end
      2'd1: begin
        if (len == 2'd2) begin
          ob = '{last: 1'b1, data: {2'b10, unit[5:0]}};
        end else begin
          ob = '{last: 1'b0, data: {2'b10, unit[11:6]}};
        end
      end
      default: ob = '{last: 1'b1, data: {2'b10, unit[5:0]}};
    endcase
    return ob;
  endfunction

endpackage

// ===== src/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts raw bytes, holds the first byte of each pair and pushes finished
// 16-bit code units into the queue. Also holds the byte-order register.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  u16u8_pkg::byte_t  in_byte,
  input  logic              in_drop,
  input  u16u8_pkg::qstat_t qstat,
  output u16u8_pkg::push_t  push
);

  logic             little_endian_r, little_endian_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  u16u8_pkg::byte_t pend_byte_r, pend_byte_nxt;
  logic             accept;
  logic             pairing;

  assign in_tready = ~qstat.full;
  assign accept    = in_tvalid & in_tready;
  assign pairing   = pend_valid_r & ~in_drop;

  always_comb begin
    little_endian_nxt = cfg_we ? cfg_wdata : little_endian_r;
    pend_valid_nxt    = pend_valid_r;
    pend_byte_nxt     = pend_byte_r;
    push.valid        = 1'b0;
    push.unit         = little_endian_r ? {in_byte, pend_byte_r} : {pend_byte_r, in_byte};
    if (accept) begin
      if (pairing) begin
        push.valid     = 1'b1;
        pend_valid_nxt = 1'b0;
      end else begin
        pend_byte_nxt  = in_byte;
        pend_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      little_endian_r <= 1'b1;
      pend_valid_r    <= 1'b0;
    end else begin
      little_endian_r <= little_endian_nxt;
      pend_valid_r    <= pend_valid_nxt;
    end
    pend_byte_r <= pend_byte_nxt;
  end

endmodule

// ===== src/u16u8_queue.sv =====
// ----------------------------------------------------------------------------
// u16u8_queue
// Short register queue of code units between the front and back ends.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  u16u8_pkg::push_t  push,
  input  logic              pop,
  output u16u8_pkg::unit_t  head,
  output u16u8_pkg::qstat_t qstat
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  u16u8_pkg::unit_t slot_r [DEPTH];
  logic [IdxW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [IdxW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign qstat.full  = (count_r == CntW'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push.valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.unit;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !qstat.full)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");

endmodule

// ===== src/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// u16u8_back
// Takes code units from the queue and sends them out as UTF-8 bytes through
// a registered output stage, one byte per cycle while out_tready holds and units are queued.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u16u8_pkg::unit_t  head,
  input  u16u8_pkg::qstat_t qstat,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output u16u8_pkg::byte_t  out_byte,
  output logic              out_last
);

  logic               busy_r, busy_nxt;
  u16u8_pkg::unit_t   unit_r, unit_nxt;
  u16u8_pkg::bidx_t   idx_r, idx_nxt;
  logic               ovalid_r, ovalid_nxt;
  u16u8_pkg::obyte_t  obyte_r, obyte_nxt;
  logic               load;

  assign load       = ~ovalid_r | out_tready;
  assign out_tvalid = ovalid_r;
  assign out_byte   = obyte_r.data;
  assign out_last   = obyte_r.last;

  always_comb begin
    busy_nxt   = busy_r;
    unit_nxt   = unit_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    pop        = 1'b0;
    if (load) begin
      if (busy_r) begin
        ovalid_nxt = 1'b1;
        obyte_nxt  = u16u8_pkg::utf8_byte(unit_r, idx_r);
        if (idx_r + 2'd1 == u16u8_pkg::utf8_len(unit_r)) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end else if (!qstat.empty) begin
        pop        = 1'b1;
        ovalid_nxt = 1'b1;
        obyte_nxt  = u16u8_pkg::utf8_byte(head, 2'd0);
        unit_nxt   = head;
        idx_nxt    = 2'd1;
        busy_nxt   = (u16u8_pkg::utf8_len(head) != 2'd1);
      end else begin
        ovalid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
    unit_r  <= unit_nxt;
    obyte_r <= obyte_nxt;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r != 2'd0) && (idx_r < u16u8_pkg::utf8_len(unit_r)))
    else $error("byte index outside the current code unit");

  a_busy_needs_open_byte: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ovalid_r && !obyte_r.last)
    else $error("unit still in progress after its final byte was staged");

endmodule

// ===== src/utf16_to_utf8_stream_core.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_stream_core
// Converts a raw UTF-16 byte stream into UTF-8 bytes, one code unit at a time.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                              Handshake
//   in_      slave      tdata[7:0] byte, tuser drop pending  tvalid/tready
//   out_     master     tdata[7:0] UTF-8 byte, tlast         tvalid/tready
//   cfg_     write      wdata: little endian byte order      we, no wait
//
// An input byte is taken in every cycle while the unit queue has space, so a
// code unit needs two input transfers. The serialiser gives one to three
// UTF-8 bytes per unit and at most one output byte per cycle; a run of
// three-byte units holds back the input once the queue is full. The first
// byte of a unit reaches out_ through the unit queue and the registered
// output stage, when the serialiser is free and the output register loads.
// Reset is synchronous with rst_n low; no clearing pass.
// Either side may stall on its own: the queue absorbs up to FIFO_DEPTH units.
//
// Bytes are paired in the front end: the first byte of a pair is held until
// its partner arrives, then the unit is formed under the current byte order
// and pushed into the queue. A transfer with tuser set discards a held byte
// so that its own byte opens a new pair. Surrogates are encoded as plain
// UCS-2 units in three bytes each.
// ----------------------------------------------------------------------------
module utf16_to_utf8_stream_core #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration: bit 0 is little_endian.
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  // Input stream.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] drop_pending
  // Output stream.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  u16u8_pkg::push_t  push;
  u16u8_pkg::qstat_t qstat;
  u16u8_pkg::unit_t  head;
  logic              pop;

  // Front end: byte pairing and the byte-order register.
  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_drop   (in_tuser),
    .qstat     (qstat),
    .push      (push)
  );

  // Queue of finished code units that decouples the two ends.
  u16u8_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Back end: UTF-8 serialiser with a registered output stage.
  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

// ===== sim/u16u8_stream_checker.sv =====
// ----------------------------------------------------------------------------
// u16u8_stream_checker
// Watches the byte order register, the input byte stream and the UTF-8
// output stream of the converter. It pairs accepted input bytes into code
// units and encodes each one into the UTF-8 bytes it must produce. Every
// output transfer is then compared with the oldest of those bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u16u8_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int unsigned mismatch_count,
  output int unsigned utf8_backlog
);

  u16u8_pkg::obyte_t utf8_due_q[$];
  u16u8_pkg::obyte_t want;
  logic              order_le;
  logic              held_valid;
  u16u8_pkg::byte_t  held_byte;
  int unsigned       beat_no;

  initial begin
    mismatch_count = 0;
    utf8_backlog   = 0;
    beat_no        = 0;
    order_le       = 1'b1;
    held_valid     = 1'b0;
    held_byte      = '0;
  end

  // Appends one predicted byte at the tail of the queue.
  function automatic void due_add(u16u8_pkg::obyte_t ob);
    utf8_due_q = {utf8_due_q, ob};
  endfunction

  // Queues the UTF-8 bytes of one code unit, leading byte first.
  function automatic void encode_unit(u16u8_pkg::unit_t u);
    if (u < 16'h0080) begin
      due_add('{last: 1'b1, data: u[7:0]});
    end else if (u < 16'h0800) begin
      due_add('{last: 1'b0, data: 8'hC0 | u16u8_pkg::byte_t'(u[10:6])});
      due_add('{last: 1'b1, data: 8'h80 | u16u8_pkg::byte_t'(u[5:0])});
    end else begin
      due_add('{last: 1'b0, data: 8'hE0 | u16u8_pkg::byte_t'(u[15:12])});
      due_add('{last: 1'b0, data: 8'h80 | u16u8_pkg::byte_t'(u[11:6])});
      due_add('{last: 1'b1, data: 8'h80 | u16u8_pkg::byte_t'(u[5:0])});
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      order_le   = 1'b1;
      held_valid = 1'b0;
      utf8_due_q.delete();
    end else begin
      if (cfg_we) begin
        order_le = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          held_valid = 1'b0;
        end
        if (!held_valid) begin
          held_byte  = in_tdata;
          held_valid = 1'b1;
        end else begin
          // The byte order in force when the second byte arrives decides.
          encode_unit(order_le ? {in_tdata, held_byte} : {held_byte, in_tdata});
          held_valid = 1'b0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (utf8_due_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%t: unexpected UTF-8 byte %02h last %0b", $realtime,
                     out_tdata, out_tlast);
          end
          mismatch_count++;
        end else begin
          want = utf8_due_q.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.last) begin
            if (mismatch_count < 10) begin
              $display("%t: UTF-8 byte %0d: expected %02h last %0b, got %02h last %0b",
                       $realtime, beat_no, want.data, want.last, out_tdata, out_tlast);
            end
            mismatch_count++;
          end
        end
        beat_no++;
      end
    end
    utf8_backlog = utf8_due_q.size();
  end

endmodule

// ===== sim/tb_utf16_to_utf8_stream_core.sv =====
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_stream_core
// Feeds the converter a directed byte sequence covering the UTF-8 length
// boundaries, surrogates, pending byte discards and a byte order change in
// the middle of a pair, then several hundred random bytes under both byte
// orders. The sender works in bursts and the receiver stalls on a pattern
// of its own; a checker module predicts and compares the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf16_to_utf8_stream_core;

  // All block inputs start at a known value.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int unsigned mismatch_count;
  int unsigned utf8_backlog;

  // Byte order the stimulus packs its code units in; mirrors the register.
  logic        byte_order_le = 1'b1;
  int unsigned burst_left    = 0;

  logic [15:0] ready_pat  = 16'hFFFF;
  int unsigned ready_span = 0;

  always #6 clk = ~clk;

  utf16_to_utf8_stream_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_byte
    .in_tuser   (in_tuser),   // [0] drop_pending
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte
    .out_tlast  (out_tlast)
  );

  u16u8_stream_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .utf8_backlog   (utf8_backlog)
  );

  // Receiver: a 16-bit ready pattern rotates for a random span and is then
  // reloaded. Some patterns are all ones, giving stretches without stalls,
  // others are sparse so that the unit queue fills and backs up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_pat  <= 16'hFFFF;
      ready_span <= 0;
    end else if (ready_span == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat <= 16'hFFFF;
        1:       ready_pat <= 16'($urandom);
        2:       ready_pat <= 16'($urandom | $urandom);
        default: ready_pat <= 16'($urandom & $urandom) | 16'h0001;
      endcase
      ready_span <= $urandom_range(8, 64);
      out_tready <= ready_pat[0];
    end else begin
      ready_pat  <= {ready_pat[0], ready_pat[15:1]};
      ready_span <= ready_span - 1;
      out_tready <= ready_pat[0];
    end
  end

  // Offers one byte and returns in the cycle its transfer completes. Bursts
  // of random length are separated by random gaps with tvalid low; valid is
  // never dropped and raised within one time step.
  task automatic put_byte(input u16u8_pkg::byte_t data_b, input logic drop);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data_b;
    in_tuser  <= drop;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // Sends a code unit as two bytes in the current byte order.
  task automatic put_unit(input u16u8_pkg::unit_t u, input logic lead_drop);
    if (byte_order_le) begin
      put_byte(u[7:0], lead_drop);
      put_byte(u[15:8], 1'b0);
    end else begin
      put_byte(u[15:8], lead_drop);
      put_byte(u[7:0], 1'b0);
    end
  endtask

  // Waits until every predicted byte has arrived, then lets the clock run on idle.
  task automatic wait_drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (utf8_backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write while the block is idle; a held odd byte may remain.
  task automatic set_byte_order(input logic le);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= le;
    @(posedge clk);
    cfg_we    <= 1'b0;
    byte_order_le = le;
  endtask

  // One random transfer group: mostly well-formed pairs with the units
  // spread over every UTF-8 length, plus lone bytes and broken pairs.
  task automatic put_random;
    u16u8_pkg::unit_t u;
    case ($urandom_range(0, 9))
      0, 1:    u = u16u8_pkg::unit_t'($urandom_range(16'h0000, 16'h007F));
      2, 3:    u = u16u8_pkg::unit_t'($urandom_range(16'h0080, 16'h07FF));
      4:       u = u16u8_pkg::unit_t'($urandom_range(16'hD800, 16'hDFFF));
      5: begin
        case ($urandom_range(0, 5))
          0:       u = 16'h0000;
          1:       u = 16'h007F;
          2:       u = 16'h0080;
          3:       u = 16'h07FF;
          4:       u = 16'h0800;
          default: u = 16'hFFFF;
        endcase
      end
      default: u = u16u8_pkg::unit_t'($urandom);
    endcase
    case ($urandom_range(0, 19))
      // A lone byte with a random discard flag shifts the pairing.
      0, 1: put_byte(u16u8_pkg::byte_t'($urandom), 1'($urandom));
      // A broken pair: the second byte discards the first and opens anew.
      2: begin
        put_byte(u[7:0], 1'b0);
        put_byte(u[15:8], 1'b1);
      end
      default: put_unit(u, $urandom_range(0, 7) == 0);
    endcase
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, little endian after reset: the UTF-8 length boundaries
    // and a surrogate, which is encoded on its own in three bytes.
    put_unit(16'h0000, 1'b0);
    put_unit(16'h007F, 1'b0);
    put_unit(16'h0080, 1'b0);
    put_unit(16'h07FF, 1'b0);
    put_unit(16'h0800, 1'b0);
    put_unit(16'hFFFF, 1'b0);
    put_unit(16'hD800, 1'b0);
    // Discard with nothing held only takes the byte.
    put_byte(8'h41, 1'b1);
    put_byte(8'h00, 1'b0);
    // Discard with a byte held: 0x12 is lost, 0x34 opens the pair.
    put_byte(8'h12, 1'b0);
    put_byte(8'h34, 1'b1);
    put_byte(8'h56, 1'b0);
    // Byte order changes between the two halves of a pair; the held byte
    // is taken as the high byte because the second one arrives big endian.
    put_byte(8'hAB, 1'b0);
    set_byte_order(1'b0);
    put_byte(8'hCD, 1'b0);
    put_unit(16'h007F, 1'b0);
    put_unit(16'h07FF, 1'b0);

    // Random phases under both byte orders.
    set_byte_order(1'b1);
    repeat (40) put_random();
    set_byte_order(1'b0);
    repeat (40) put_random();
    set_byte_order(1'b1);
    repeat (40) put_random();
    set_byte_order(1'($urandom));
    repeat (40) put_random();
    set_byte_order(1'b0);
    repeat (40) put_random();

    wait_drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && utf8_backlog == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
